// ----- hw/rtl/cv_ct_pkg.sv -----
// Package for the coordinated-turn motion step core.
// Holds field widths, reset values, action and register codes and the
// rounding multiply shared by the datapath. No dependencies.
package cv_ct_pkg;

  localparam int FIELD_W       = 32;
  localparam int PROD_W        = 2 * FIELD_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int NUM_IN_DATA   = 8;
  localparam int NUM_OUT       = 5;
  localparam int IN_DATA_W     = NUM_IN_DATA * FIELD_W;
  localparam int OUT_DATA_W    = NUM_OUT * FIELD_W;
  localparam int ACTION_W      = 2;
  localparam int CFG_IDX_W     = 3;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int PERIOD_W = 31;
  localparam int TRIG_W   = 18;

  localparam logic [PERIOD_W-1:0]       PERIOD_RST   = 31'd65536;
  localparam logic [PERIOD_W-1:0]       HALF_SQ_RST  = 31'd32768;
  localparam logic signed [FIELD_W-1:0] SIN_OVR_RST  = 32'sd65536;
  localparam logic signed [FIELD_W-1:0] OMC_OVR_RST  = 32'sd0;
  localparam logic signed [TRIG_W-1:0]  COS_RST      = 18'sd65536;
  localparam logic signed [TRIG_W-1:0]  SIN_RST      = 18'sd0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_UNIFORM = 2'd1,
    ACT_TURN    = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD  = 3'd0,
    REG_HALF_SQ = 3'd1,
    REG_SIN_OVR = 3'd2,
    REG_OMC_OVR = 3'd3,
    REG_COS     = 3'd4,
    REG_SIN     = 3'd5
  } cfg_reg_t;

  // Exact product, round half up, floor shift by frac.
  function automatic logic signed [SUM_W-1:0] qmul(
    input logic signed [FIELD_W-1:0] a,
    input logic signed [FIELD_W-1:0] b,
    input int unsigned               frac
  );
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    p = p + (PROD_W'(1) <<< (frac - 1));
    return SUM_W'(p >>> frac);
  endfunction

endpackage

// ----- hw/rtl/cv_ct_motion_step_core.sv -----
// Coordinated-turn / uniform-motion target state step, Q16.16 default.
// The result passes through the input register, then the result register;
// throughput one request per cycle unless m_axis_tready stalls the output,
// set by the state update loop. Synchronous active-high reset clears
// the state to zero, the configuration registers to their defaults and
// empties both pipeline registers.
module cv_ct_motion_step_core #(
  parameter int DATA_WIDTH = cv_ct_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cv_ct_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // noise_x, noise_y, noise_turn, init_pos_x, init_vel_x, init_pos_y,
  // init_vel_y, init_turn (32 bits each, lowest first)
  input  logic [cv_ct_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action
  input  logic [cv_ct_pkg::ACTION_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_pos_x, out_vel_x, out_pos_y, out_vel_y, out_turn (32 bits each)
  output logic [cv_ct_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cv_ct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cv_ct_pkg::FIELD_W-1:0]       cfg_data
);

  localparam int FW = cv_ct_pkg::FIELD_W;
  localparam int SW = (DATA_WIDTH > FW) ? FW : DATA_WIDTH;
  localparam int SUMW = cv_ct_pkg::SUM_W;
  localparam int unsigned FB = FRAC_BITS;

  function automatic logic signed [SW-1:0] sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = SUMW'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - SUMW'(1);
    if (v > hi) begin
      return SW'(hi);
    end else if (v < lo) begin
      return SW'(lo);
    end
    return SW'(v);
  endfunction

  // configuration
  logic [cv_ct_pkg::PERIOD_W-1:0] sample_period;
  logic [cv_ct_pkg::PERIOD_W-1:0] half_period_sq;
  logic signed [FW-1:0]           turn_sin_over_rate;
  logic signed [FW-1:0]           turn_omc_over_rate;
  logic signed [cv_ct_pkg::TRIG_W-1:0] turn_cos;
  logic signed [cv_ct_pkg::TRIG_W-1:0] turn_sin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period      <= cv_ct_pkg::PERIOD_RST;
      half_period_sq     <= cv_ct_pkg::HALF_SQ_RST;
      turn_sin_over_rate <= cv_ct_pkg::SIN_OVR_RST;
      turn_omc_over_rate <= cv_ct_pkg::OMC_OVR_RST;
      turn_cos           <= cv_ct_pkg::COS_RST;
      turn_sin           <= cv_ct_pkg::SIN_RST;
    end else if (cfg_valid) begin
      unique case (cv_ct_pkg::cfg_reg_t'(cfg_index))
        cv_ct_pkg::REG_PERIOD:  sample_period      <= cfg_data[cv_ct_pkg::PERIOD_W-1:0];
        cv_ct_pkg::REG_HALF_SQ: half_period_sq     <= cfg_data[cv_ct_pkg::PERIOD_W-1:0];
        cv_ct_pkg::REG_SIN_OVR: turn_sin_over_rate <= cfg_data;
        cv_ct_pkg::REG_OMC_OVR: turn_omc_over_rate <= cfg_data;
        cv_ct_pkg::REG_COS:     turn_cos           <= cfg_data[cv_ct_pkg::TRIG_W-1:0];
        cv_ct_pkg::REG_SIN:     turn_sin           <= cfg_data[cv_ct_pkg::TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  logic                               in_valid;
  logic [cv_ct_pkg::IN_DATA_W-1:0]    in_data;
  logic [cv_ct_pkg::ACTION_W-1:0]     in_action;
  logic                               adv;

  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data   <= s_axis_tdata;
      in_action <= s_axis_tuser;
    end
  end

  logic signed [FW-1:0] nx, ny, nt, ipx, ivx, ipy, ivy, itr;
  assign nx  = in_data[0*FW +: FW];
  assign ny  = in_data[1*FW +: FW];
  assign nt  = in_data[2*FW +: FW];
  assign ipx = in_data[3*FW +: FW];
  assign ivx = in_data[4*FW +: FW];
  assign ipy = in_data[5*FW +: FW];
  assign ivy = in_data[6*FW +: FW];
  assign itr = in_data[7*FW +: FW];

  // state
  logic signed [SW-1:0] pos_x, vel_x, pos_y, vel_y, turn_state;
  logic signed [SW-1:0] pos_x_next, vel_x_next, pos_y_next, vel_y_next, turn_next;

  logic signed [FW-1:0] vx, vy, tp, hp, sor, oor, cs, sn;
  assign vx  = FW'(vel_x);
  assign vy  = FW'(vel_y);
  assign tp  = FW'(sample_period);
  assign hp  = FW'(half_period_sq);
  assign sor = turn_sin_over_rate;
  assign oor = turn_omc_over_rate;
  assign cs  = FW'(turn_cos);
  assign sn  = FW'(turn_sin);

  logic signed [SUMW-1:0] t_vx, t_vy, h_nx, h_ny, t_nx, t_ny, t_nt;
  logic signed [SUMW-1:0] s_vx, s_vy, o_vx, o_vy, c_vx, c_vy, n_vx, n_vy;
  logic signed [SUMW-1:0] px_w, py_w, vx_w, vy_w, tr_w;

  assign t_vx = cv_ct_pkg::qmul(tp, vx, FB);
  assign t_vy = cv_ct_pkg::qmul(tp, vy, FB);
  assign h_nx = cv_ct_pkg::qmul(hp, nx, FB);
  assign h_ny = cv_ct_pkg::qmul(hp, ny, FB);
  assign t_nx = cv_ct_pkg::qmul(tp, nx, FB);
  assign t_ny = cv_ct_pkg::qmul(tp, ny, FB);
  assign t_nt = cv_ct_pkg::qmul(tp, nt, FB);
  assign s_vx = cv_ct_pkg::qmul(sor, vx, FB);
  assign s_vy = cv_ct_pkg::qmul(sor, vy, FB);
  assign o_vx = cv_ct_pkg::qmul(oor, vx, FB);
  assign o_vy = cv_ct_pkg::qmul(oor, vy, FB);
  assign c_vx = cv_ct_pkg::qmul(cs, vx, FB);
  assign c_vy = cv_ct_pkg::qmul(cs, vy, FB);
  assign n_vx = cv_ct_pkg::qmul(sn, vx, FB);
  assign n_vy = cv_ct_pkg::qmul(sn, vy, FB);

  assign px_w = SUMW'(pos_x);
  assign py_w = SUMW'(pos_y);
  assign vx_w = SUMW'(vel_x);
  assign vy_w = SUMW'(vel_y);
  assign tr_w = SUMW'(turn_state);

  always_comb begin
    pos_x_next = pos_x;
    vel_x_next = vel_x;
    pos_y_next = pos_y;
    vel_y_next = vel_y;
    turn_next  = turn_state;
    unique case (cv_ct_pkg::action_t'(in_action))
      cv_ct_pkg::ACT_LOAD: begin
        pos_x_next = sat(SUMW'(ipx));
        vel_x_next = sat(SUMW'(ivx));
        pos_y_next = sat(SUMW'(ipy));
        vel_y_next = sat(SUMW'(ivy));
        turn_next  = sat(SUMW'(itr));
      end
      cv_ct_pkg::ACT_UNIFORM: begin
        pos_x_next = sat(px_w + t_vx + h_nx);
        vel_x_next = sat(vx_w + t_nx);
        pos_y_next = sat(py_w + t_vy + h_ny);
        vel_y_next = sat(vy_w + t_ny);
        turn_next  = sat(t_nt);
      end
      cv_ct_pkg::ACT_TURN: begin
        pos_x_next = sat(px_w + s_vx - o_vy + h_nx);
        vel_x_next = sat(c_vx - n_vy + t_nx);
        pos_y_next = sat(py_w + o_vx + s_vy + h_ny);
        vel_y_next = sat(n_vx + c_vy + t_ny);
        turn_next  = sat(tr_w + t_nt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      vel_x      <= '0;
      pos_y      <= '0;
      vel_y      <= '0;
      turn_state <= '0;
    end else if (adv) begin
      pos_x      <= pos_x_next;
      vel_x      <= vel_x_next;
      pos_y      <= pos_y_next;
      vel_y      <= vel_y_next;
      turn_state <= turn_next;
    end
  end

  // result register
  logic signed [SW-1:0] out_pos_x, out_vel_x, out_pos_y, out_vel_y, out_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_x <= pos_x_next;
      out_vel_x <= vel_x_next;
      out_pos_y <= pos_y_next;
      out_vel_y <= vel_y_next;
      out_turn  <= turn_next;
    end
  end

  assign m_axis_tdata[0*FW +: FW] = FW'(out_pos_x);
  assign m_axis_tdata[1*FW +: FW] = FW'(out_vel_x);
  assign m_axis_tdata[2*FW +: FW] = FW'(out_pos_y);
  assign m_axis_tdata[3*FW +: FW] = FW'(out_vel_y);
  assign m_axis_tdata[4*FW +: FW] = FW'(out_turn);

endmodule
